>>> rtl/indexed_list_engine_top_assert.svh
// Assertion macros used by the indexed list engine top.
`ifndef INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define ILE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list engine: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define ILE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list engine: next-cycle check failed");
`else
`define ILE_ASSERT_NOW(label, ante, cons)
`define ILE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/ile_pkg.sv
// Package with sizes, operation codes and the cell command type.
`default_nettype none
package ile_pkg;
  localparam int DEPTH   = 64;
  localparam int IDXW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW    = $clog2(DEPTH + 1);
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 7;
  localparam int OP_W    = 4;
  localparam int DATA_W  = 32;
  localparam int CMPW    = (CNTW > INDEX_W) ? CNTW : INDEX_W;
  localparam int GRP     = 8;
  localparam int NGRP    = (DEPTH + GRP - 1) / GRP;

  localparam logic [OP_W-1:0] OP_ADD_LAST   = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD_FIRST  = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD_AT     = 4'd2;
  localparam logic [OP_W-1:0] OP_TAKE_LAST  = 4'd3;
  localparam logic [OP_W-1:0] OP_TAKE_FIRST = 4'd4;
  localparam logic [OP_W-1:0] OP_TAKE_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_PEEK_LAST  = 4'd6;
  localparam logic [OP_W-1:0] OP_PEEK_FIRST = 4'd7;
  localparam logic [OP_W-1:0] OP_PEEK_AT    = 4'd8;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic                     rd;
    logic [IDXW-1:0]          pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;
endpackage
`default_nettype wire

>>> rtl/ile_in_if.sv
// Request channel interface: valid, ready and the request payload.
`default_nettype none
interface ile_in_if
  import ile_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [DATA_W-1:0]  value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink (input valid, input op, input value, input index, output ready);
endinterface
`default_nettype wire

>>> rtl/ile_out_if.sv
// Result channel interface: valid, ready and the result payload.
`default_nettype none
interface ile_out_if
  import ile_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic signed [DATA_W-1:0]  data;
  logic [COUNT_W-1:0]        count;
  logic                      empty_res;

  modport source (output valid, output ok, output data, output count, output empty_res,
                  input ready);
  modport sink (input valid, input ok, input data, input count, input empty_res,
                output ready);
endinterface
`default_nettype wire

>>> rtl/ile_cell.sv
// One list entry cell: holds a value and shifts with its neighbors.
`default_nettype none
module ile_cell
  import ile_pkg::*;
(
  input  wire                       clk,
  input  wire cell_cmd_t            cmd_i,
  input  wire [IDXW-1:0]            pos_id_i,
  input  wire signed [DATA_W-1:0]   left_i,
  input  wire signed [DATA_W-1:0]   right_i,
  output logic signed [DATA_W-1:0]  q_o,
  output logic signed [DATA_W-1:0]  sel_o
);
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  // Insert moves later entries up; remove pulls them down over the gap.
  always_comb begin
    val_nxt = val_r;
    if (cmd_i.ins) begin
      if (pos_id_i > cmd_i.pos) begin
        val_nxt = left_i;
      end else if (pos_id_i == cmd_i.pos) begin
        val_nxt = cmd_i.value;
      end
    end else if (cmd_i.rem) begin
      if (pos_id_i >= cmd_i.pos) begin
        val_nxt = right_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q_o   = val_r;
  // Only the addressed cell drives its value into the read tree.
  assign sel_o = (cmd_i.rd && (pos_id_i == cmd_i.pos)) ? val_r : '0;
endmodule
`default_nettype wire

>>> rtl/ile_grp.sv
// Registered OR of one group of cell read values, loaded on a read.
`default_nettype none
module ile_grp
  import ile_pkg::*;
(
  input  wire                       clk,
  input  wire                       en_i,
  input  wire signed [DATA_W-1:0]   vals_i [GRP],
  output logic signed [DATA_W-1:0]  grp_o
);
  logic signed [DATA_W-1:0] grp_r;
  logic signed [DATA_W-1:0] grp_nxt;

  // At most one input is nonzero, so an OR picks it.
  always_comb begin
    grp_nxt = '0;
    for (int k = 0; k < GRP; k++) begin
      grp_nxt = grp_nxt | vals_i[k];
    end
  end

  // The value is held until the next read, so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (en_i) begin
      grp_r <= grp_nxt;
    end
  end

  assign grp_o = grp_r;
endmodule
`default_nettype wire

>>> rtl/indexed_list_engine_top.sv
// Sequence per request: it is accepted in S_IDLE, then in S_EXEC the cells shift and the read
// groups register, then S_FIN loads the result register and returns to S_IDLE; no new request
// is accepted until then.
// A new request is accepted while the previous result waits in the output register.
// A result that finds the output register still full holds the sequencer and the input.
// Reset (synchronous, rst_n low) empties the list; cell contents are not cleared.
`default_nettype none
`include "indexed_list_engine_top_assert.svh"
module indexed_list_engine_top
  import ile_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  ile_in_if.sink    in_ch,
  ile_out_if.source out_ch
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_t;

  state_t                   state_r, state_nxt;
  logic [OP_W-1:0]          op_r;
  logic signed [DATA_W-1:0] value_r;
  logic [INDEX_W-1:0]       index_r;
  logic [CNTW-1:0]          fill_r, fill_nxt;
  logic                     ok_r, ok_nxt;
  logic                     rd_r, rd_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ok_r, out_ok_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [CNTW-1:0]          out_fill_r, out_fill_nxt;

  logic                     in_acc;
  logic                     is_add, is_take, is_peek;
  logic [CMPW-1:0]          f_w, pos_w;
  logic                     dec_ok;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] q    [DEPTH];
  logic signed [DATA_W-1:0] sel  [DEPTH];
  logic signed [DATA_W-1:0] grp  [NGRP];
  logic signed [DATA_W-1:0] rd_data;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Decode the held request against the current fill.
  always_comb begin
    is_add  = 1'b0;
    is_take = 1'b0;
    is_peek = 1'b0;
    f_w     = CMPW'(fill_r);
    pos_w   = '0;
    unique case (op_r) inside
      OP_ADD_LAST:                                   pos_w = f_w;
      OP_TAKE_LAST, OP_PEEK_LAST:                    pos_w = f_w - CMPW'(1);
      OP_ADD_AT, OP_TAKE_AT, OP_PEEK_AT:             pos_w = CMPW'(index_r);
      default:                                       pos_w = '0;
    endcase
    unique case (op_r) inside
      OP_ADD_LAST, OP_ADD_FIRST, OP_ADD_AT:          is_add  = 1'b1;
      OP_TAKE_LAST, OP_TAKE_FIRST, OP_TAKE_AT:       is_take = 1'b1;
      OP_PEEK_LAST, OP_PEEK_FIRST, OP_PEEK_AT:       is_peek = 1'b1;
      default: ;
    endcase
    if (is_add) begin
      dec_ok = (f_w < CMPW'(DEPTH)) && (pos_w <= f_w);
    end else if (is_take || is_peek) begin
      dec_ok = (f_w != '0) && (pos_w < f_w);
    end else begin
      dec_ok = 1'b0;
    end
  end

  // Cell command is live only in the execute cycle.
  always_comb begin
    cmd.ins   = (state_r == S_EXEC) && dec_ok && is_add;
    cmd.rem   = (state_r == S_EXEC) && dec_ok && is_take;
    cmd.rd    = (state_r == S_EXEC) && dec_ok && (is_take || is_peek);
    cmd.pos   = pos_w[IDXW-1:0];
    cmd.value = value_r;
  end

  // Chain of entry cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = q[i];
    end else begin : g_mid
      assign left_v = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = q[i];
    end else begin : g_notlast
      assign right_v = q[i+1];
    end
    ile_cell u_cell (
      .clk      (clk),
      .cmd_i    (cmd),
      .pos_id_i (IDXW'(i)),
      .left_i   (left_v),
      .right_i  (right_v),
      .q_o      (q[i]),
      .sel_o    (sel[i])
    );
  end

  // First level of the read tree: registered groups of cells.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic signed [DATA_W-1:0] vals [GRP];
    for (genvar k = 0; k < GRP; k++) begin : g_tap
      if (g * GRP + k < DEPTH) begin : g_real
        assign vals[k] = sel[g*GRP+k];
      end else begin : g_pad
        assign vals[k] = '0;
      end
    end
    ile_grp u_grp (
      .clk    (clk),
      .en_i   (cmd.rd),
      .vals_i (vals),
      .grp_o  (grp[g])
    );
  end

  // Second level of the read tree.
  always_comb begin
    rd_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_data = rd_data | grp[g];
    end
  end

  // Sequencer next state, fill and result register.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ok_nxt        = ok_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_data_nxt  = out_data_r;
    out_fill_nxt  = out_fill_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ok_nxt = dec_ok;
        rd_nxt = cmd.rd;
        if (cmd.ins) begin
          fill_nxt = fill_r + CNTW'(1);
        end else if (cmd.rem) begin
          fill_nxt = fill_r - CNTW'(1);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_data_nxt  = rd_r ? rd_data : '0;
          out_fill_nxt  = fill_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      rd_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
      rd_r        <= rd_nxt;
    end
    out_ok_r   <= out_ok_nxt;
    out_data_r <= out_data_nxt;
    out_fill_r <= out_fill_nxt;
    if (in_acc) begin
      op_r    <= in_ch.op;
      value_r <= in_ch.value;
      index_r <= in_ch.index;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.data      = out_data_r;
  assign out_ch.count     = COUNT_W'(out_fill_r);
  assign out_ch.empty_res = (out_fill_r == '0);

  // The fill never passes the list depth.
  `ILE_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNTW'(DEPTH))
  // An accepted request goes straight to the execute cycle.
  `ILE_ASSERT_NEXT(a_acc_exec, in_acc, state_r == S_EXEC)
  // A rejected request leaves the fill unchanged.
  `ILE_ASSERT_NEXT(a_rej_hold, (state_r == S_EXEC) && !dec_ok, fill_r == $past(fill_r))
  // A failed result never carries data.
  `ILE_ASSERT_NOW(a_fail_zero, out_valid_r && !out_ok_r, out_data_r == '0)
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for indexed_list_engine_top: a directed table, then random requests.
`timescale 1ns / 1ps
module tb;
  import ile_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_REQUESTS = 1150;
  localparam int SEGMENT_LEN     = 96;
  localparam int MAX_WAIT        = 11;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 100;

  // Operation codes above the last defined one; the block must reject them.
  localparam logic [OP_W-1:0] OP_UNUSED_LOW  = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED_HIGH = 4'd15;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     empty_res;
  } list_result_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [INDEX_W-1:0]       index;
    bit                       typed;
    list_result_t             want;
  } request_row_t;

  logic clk;
  logic rst_n;

  ile_in_if  in_ch();
  ile_out_if out_ch();

  indexed_list_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list contents, front at position 0.
  logic signed [DATA_W-1:0] list_copy[$];
  list_result_t             pending_results[$];
  request_row_t             directed_rows[$];
  int                       error_count;
  int                       results_seen;
  int                       quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow list and returns the result it should produce.
  function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] value,
                                                 input logic [INDEX_W-1:0] index);
    list_result_t res;
    int  fill;
    int  pos;
    bit  is_add;
    bit  is_take;
    bit  is_peek;
    fill    = list_copy.size();
    res     = '0;
    pos     = 0;
    is_add  = 1'b0;
    is_take = 1'b0;
    is_peek = 1'b0;
    case (op)
      OP_ADD_LAST:   begin is_add = 1'b1;  pos = fill;     end
      OP_ADD_FIRST:  begin is_add = 1'b1;  pos = 0;        end
      OP_ADD_AT:     begin is_add = 1'b1;  pos = index;    end
      OP_TAKE_LAST:  begin is_take = 1'b1; pos = fill - 1; end
      OP_TAKE_FIRST: begin is_take = 1'b1; pos = 0;        end
      OP_TAKE_AT:    begin is_take = 1'b1; pos = index;    end
      OP_PEEK_LAST:  begin is_peek = 1'b1; pos = fill - 1; end
      OP_PEEK_FIRST: begin is_peek = 1'b1; pos = 0;        end
      OP_PEEK_AT:    begin is_peek = 1'b1; pos = index;    end
      default: ;
    endcase
    // An add may land anywhere up to one past the last entry; reads need an existing entry.
    if (is_add && fill < DEPTH && pos <= fill) begin
      list_copy.insert(pos, value);
      res.ok = 1'b1;
    end else if ((is_take || is_peek) && pos >= 0 && pos < fill) begin
      res.ok   = 1'b1;
      res.data = list_copy[pos];
      if (is_take) list_copy.delete(pos);
    end
    res.count     = COUNT_W'(list_copy.size());
    res.empty_res = (list_copy.size() == 0);
    return res;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                         input logic [INDEX_W-1:0] index, input bit typed, input logic ok,
                         input logic signed [DATA_W-1:0] data, input int count);
    request_row_t row;
    row.op             = op;
    row.value          = value;
    row.index          = index;
    row.typed          = typed;
    row.want.ok        = ok;
    row.want.data      = data;
    row.want.count     = COUNT_W'(count);
    row.want.empty_res = (count == 0);
    directed_rows.push_back(row);
  endtask

  // Directed part: empty-list rejections, unused codes, field extremes, every operation.
  task automatic build_directed_rows();
    add_row(OP_TAKE_FIRST,  32'sd0,        7'd0,   1, 1'b0, 32'sd0, 0);
    add_row(OP_TAKE_LAST,   32'sd0,        7'd0,   1, 1'b0, 32'sd0, 0);
    add_row(OP_TAKE_AT,     32'sd0,        7'd64,  1, 1'b0, 32'sd0, 0);
    add_row(OP_PEEK_FIRST,  32'sd0,        7'd0,   1, 1'b0, 32'sd0, 0);
    add_row(OP_PEEK_LAST,   32'sd0,        7'd0,   1, 1'b0, 32'sd0, 0);
    add_row(OP_PEEK_AT,     32'sd0,        7'd0,   1, 1'b0, 32'sd0, 0);
    add_row(OP_ADD_AT,      32'sd5,        7'd1,   1, 1'b0, 32'sd0, 0);
    add_row(OP_UNUSED_LOW,  -32'sd1,       7'd0,   1, 1'b0, 32'sd0, 0);
    add_row(OP_UNUSED_HIGH, -32'sd1,       7'd127, 1, 1'b0, 32'sd0, 0);
    add_row(OP_ADD_LAST,    32'h7fffffff,  7'd0,   1, 1'b1, 32'sd0, 1);
    add_row(OP_ADD_FIRST,   32'h80000000,  7'd0,   1, 1'b1, 32'sd0, 2);
    add_row(OP_ADD_AT,      -32'sd1,       7'd1,   1, 1'b1, 32'sd0, 3);
    // Index equal to the count appends at the back.
    add_row(OP_ADD_AT,      32'h5a5a5a5a,  7'd3,   1, 1'b1, 32'sd0, 4);
    add_row(OP_ADD_AT,      32'sd7,        7'd127, 1, 1'b0, 32'sd0, 4);
    add_row(OP_PEEK_FIRST,  32'sd0,        7'd0,   1, 1'b1, 32'h80000000, 4);
    add_row(OP_PEEK_LAST,   32'sd0,        7'd0,   1, 1'b1, 32'h5a5a5a5a, 4);
    add_row(OP_PEEK_AT,     32'sd0,        7'd2,   1, 1'b1, 32'h7fffffff, 4);
    add_row(OP_PEEK_AT,     32'sd0,        7'd4,   1, 1'b0, 32'sd0, 4);
    add_row(OP_TAKE_AT,     32'sd0,        7'd4,   1, 1'b0, 32'sd0, 4);
    add_row(OP_TAKE_AT,     32'sd0,        7'd1,   1, 1'b1, -32'sd1, 3);
    add_row(OP_TAKE_LAST,   32'sd0,        7'd0,   1, 1'b1, 32'h5a5a5a5a, 2);
    add_row(OP_ADD_FIRST,   32'sd0,        7'd0,   0, 1'b0, 32'sd0, 0);
    add_row(OP_TAKE_FIRST,  32'sd0,        7'd0,   0, 1'b0, 32'sd0, 0);
    add_row(OP_TAKE_FIRST,  32'sd0,        7'd0,   1, 1'b1, 32'h80000000, 1);
    add_row(OP_TAKE_AT,     32'sd0,        7'd0,   1, 1'b1, 32'h7fffffff, 0);
  endtask

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(MAX_WAIT);
  endfunction

  function automatic logic [OP_W-1:0] draw_op(input op_mix_t mix);
    int r;
    int add_w;
    int take_w;
    logic [OP_W-1:0] op;
    r      = $urandom_range(99);
    add_w  = (mix == MIX_GROW) ? 80 : (mix == MIX_SHRINK) ? 7 : 40;
    take_w = (mix == MIX_GROW) ? 7 : (mix == MIX_SHRINK) ? 80 : 35;
    if (r < 3) begin
      op = OP_W'(OP_UNUSED_LOW + $urandom_range(OP_UNUSED_HIGH - OP_UNUSED_LOW));
    end else if (r < 3 + add_w) begin
      case ($urandom_range(2))
        0:       op = OP_ADD_LAST;
        1:       op = OP_ADD_FIRST;
        default: op = OP_ADD_AT;
      endcase
    end else if (r < 3 + add_w + take_w) begin
      case ($urandom_range(2))
        0:       op = OP_TAKE_LAST;
        1:       op = OP_TAKE_FIRST;
        default: op = OP_TAKE_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       op = OP_PEEK_LAST;
        1:       op = OP_PEEK_FIRST;
        default: op = OP_PEEK_AT;
      endcase
    end
    return op;
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(9))
      0:       return 32'h80000000;
      1:       return 32'h7fffffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions inside the list or just past its end, sometimes anything the field holds.
  function automatic logic [INDEX_W-1:0] draw_index();
    case ($urandom_range(19))
      0:       return INDEX_W'($urandom_range(127));
      1, 2:    return INDEX_W'($urandom_range(DEPTH));
      default: return INDEX_W'($urandom_range(list_copy.size()));
    endcase
  endfunction

  // Offers one request after an idle gap and returns at the edge where it is accepted.
  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                              input logic [INDEX_W-1:0] index, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    in_ch.index <= index;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (error_count < MAX_REPORTS)
      $display("mismatch on result %0d: %s is %h, expected %h", results_seen, field, got, want);
    error_count++;
  endtask

  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, ok", DATA_W'(out_ch.ok), 0);
      return;
    end
    want = pending_results.pop_front();
    if (out_ch.ok !== want.ok)
      report_mismatch("ok", DATA_W'(out_ch.ok), DATA_W'(want.ok));
    if (out_ch.data !== want.data) report_mismatch("data", out_ch.data, want.data);
    if (out_ch.count !== want.count)
      report_mismatch("count", DATA_W'(out_ch.count), DATA_W'(want.count));
    if (out_ch.empty_res !== want.empty_res)
      report_mismatch("empty_res", DATA_W'(out_ch.empty_res), DATA_W'(want.empty_res));
  endtask

  // Request side: reset, directed rows, random segments, then drain and verdict.
  initial begin : request_source
    list_result_t res;
    op_mix_t      mix;
    bit           send_burst;
    int           n;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [INDEX_W-1:0]       index;
    error_count = 0;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_ADD_LAST;
    in_ch.value <= '0;
    in_ch.index <= '0;
    rst_n       <= 1'b0;
    send_burst  = 1'b0;
    mix         = MIX_EVEN;
    build_directed_rows();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].index,
                   draw_wait(send_burst));
      res = apply_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].index);
      pending_results.push_back(directed_rows[i].typed ? directed_rows[i].want : res);
    end

    // Segments alternate between filling the list and draining it, with mixed ones between.
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        case ((n / SEGMENT_LEN) % 4)
          0:       mix = MIX_GROW;
          2:       mix = MIX_SHRINK;
          default: mix = op_mix_t'($urandom_range(2));
        endcase
        send_burst = ($urandom_range(3) == 0);
      end
      op    = draw_op(mix);
      value = draw_value();
      index = draw_index();
      send_request(op, value, index, draw_wait(send_burst));
      pending_results.push_back(apply_request(op, value, index));
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("indexed_list_engine_top regression: pass");
    else
      $display("indexed_list_engine_top regression: fail");
    $finish;
  end

  // Result side: random stalls, bursts of constant readiness, and one long hold-off.
  initial begin : result_sink
    int stall;
    bit recv_burst;
    results_seen = 0;
    recv_burst   = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results_seen % 40 == 0) recv_burst = ($urandom_range(3) == 0);
      stall = draw_wait(recv_burst);
      if (results_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_result();
      results_seen++;
    end
  end

  // Watchdog: ends the run when no request or result has moved for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("indexed_list_engine_top regression: fail");
      $finish;
    end
  end

  initial quiet_cycles = 0;
endmodule

>>> indexed_list_engine_top.f
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_in_if.sv
rtl/ile_out_if.sv
rtl/ile_cell.sv
rtl/ile_grp.sv
rtl/indexed_list_engine_top.sv
tb/tb.sv
